/* rtl/dms_pkg.sv */
// ----------------------------------------------------------------------------
// dms_pkg: shared definitions for the DNA motif scanner
// Widths, register indexes, cell status type and set-mask helpers.
// ----------------------------------------------------------------------------
package dms_pkg;

	localparam int MAX_MOTIF      = 16;
	localparam int COUNT_BITS     = 32;
	localparam int MOTIF_SLOTS    = 16;
	localparam int SET_BITS       = 4;
	localparam int PATTERN_BITS   = MOTIF_SLOTS * SET_BITS;
	localparam int FIELD_LEN_BITS = 5;
	localparam int OUT_BITS       = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int LEN_BITS       = ($clog2(MAX_MOTIF + 1) > FIELD_LEN_BITS) ?
		$clog2(MAX_MOTIF + 1) : FIELD_LEN_BITS;
	localparam int GRP_SIZE       = 4;
	localparam int NGRP           = (MAX_MOTIF + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_BITS       = 3;
	localparam int LENGTH_RESET   = 16;

	typedef logic [SET_BITS-1:0]       base_t;
	typedef logic [COUNT_BITS-1:0]     count_t;
	typedef logic [LEN_BITS-1:0]       len_t;
	typedef logic [PATTERN_BITS-1:0]   pattern_t;
	typedef logic [OUT_BITS-1:0]       out_cnt_t;
	typedef logic [GRP_BITS-1:0]       grp_cnt_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MOTIF_PATTERN  = 2'd0,
		REG_MOTIF_LENGTH   = 2'd1,
		REG_MISMATCH_LIMIT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic fwd;
		logic rev;
	} cell_mis_t;

	function automatic base_t complement_set(input base_t m);
		return {m[0], m[1], m[2], m[3]};
	endfunction

	function automatic base_t motif_at(input pattern_t pattern, input len_t pos);
		base_t r;
		r = '0;
		if (pos < len_t'(MOTIF_SLOTS)) begin
			r = pattern[{pos[3:0], 2'b00} +: SET_BITS];
		end
		return r;
	endfunction

	function automatic out_cnt_t clamp_out(input count_t v);
		logic [COUNT_BITS+OUT_BITS-1:0] ext;
		out_cnt_t r;
		ext = {{OUT_BITS{1'b0}}, v};
		if (ext > {{COUNT_BITS{1'b0}}, {OUT_BITS{1'b1}}}) begin
			r = '1;
		end else begin
			r = ext[OUT_BITS-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/dms_cell.sv */
// ----------------------------------------------------------------------------
// dms_cell: one window position
// Holds one base, passes it to the next cell on a shift, and flags a
// mismatch against the forward and reverse-complement motif sets.
// ----------------------------------------------------------------------------
module dms_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift_en,
	input  dms_pkg::base_t    base_in,
	input  dms_pkg::base_t    fwd_set,
	input  dms_pkg::base_t    rev_motif,
	input  logic              in_use,
	output dms_pkg::base_t    base_out,
	output dms_pkg::cell_mis_t mis
);

	dms_pkg::base_t base_q;
	dms_pkg::base_t rev_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (shift_en) begin
			base_q <= base_in;
		end
	end

	assign rev_set  = dms_pkg::complement_set(rev_motif);
	assign base_out = base_q;
	assign mis.fwd  = in_use && ((base_q & fwd_set) == '0);
	assign mis.rev  = in_use && ((base_q & rev_set) == '0);

endmodule

/* rtl/dna_motif_scan_with_mismatches.sv */
// ----------------------------------------------------------------------------
// dna_motif_scan_with_mismatches: approximate motif scan on both strands
// Streams IUPAC base masks through a chain of window cells and reports,
// per base, forward and reverse-complement hits with running counts.
// ----------------------------------------------------------------------------
// One result per base, one base per cycle sustained while out_stall stays low.
// The result passes through four register stages: cell shift, per-group
// mismatch counts, mismatch sum and limit compare, hit tally into the
// output register. The
// window is a row of MAX_MOTIF cells shifting on every accepted base; each
// pipeline stage moves on whenever the stage after it is empty or moving, so
// the input keeps flowing while a result waits on out_stall until all four
// stages are occupied. Configuration writes are always ready and take effect
// from the next base; write them only while no base is in flight.
module dna_motif_scan_with_mismatches (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dms_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [dms_pkg::PATTERN_BITS-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [3:0]                           base_set,
	input  logic                                 sequence_start,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 window_full,
	output logic                                 forward_hit,
	output logic                                 reverse_hit,
	output logic [31:0]                          start_position,
	output logic [31:0]                          total_hits
);

	localparam int M  = dms_pkg::MAX_MOTIF;
	localparam int NG = dms_pkg::NGRP;

	dms_pkg::pattern_t                  pattern_q;
	logic [dms_pkg::FIELD_LEN_BITS-1:0] length_q;
	logic [dms_pkg::FIELD_LEN_BITS-1:0] limit_q;

	dms_pkg::len_t  len_raw;
	dms_pkg::len_t  len_eff;
	dms_pkg::len_t  lim_ext;

	logic en1, en2, en3, en4, acc;
	logic v_s1, v_s2, v_s3, v_s4;
	logic start_s1, start_s2, start_s3;

	dms_pkg::count_t seen_q;
	dms_pkg::count_t seen_d;
	dms_pkg::count_t hit_q;
	dms_pkg::count_t hit_base, hit_1, hit_2;

	dms_pkg::base_t     win [M];
	dms_pkg::base_t     chain_in [M];
	dms_pkg::cell_mis_t mis [M];

	dms_pkg::grp_cnt_t fcnt_d [NG];
	dms_pkg::grp_cnt_t rcnt_d [NG];
	dms_pkg::grp_cnt_t fcnt_s2 [NG];
	dms_pkg::grp_cnt_t rcnt_s2 [NG];
	logic              full_d, full_s2, full_s3;
	dms_pkg::out_cnt_t pos_d, pos_s2, pos_s3;

	dms_pkg::len_t fsum, rsum;
	logic          fwd_s3, rev_s3;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= dms_pkg::FIELD_LEN_BITS'(dms_pkg::LENGTH_RESET);
			limit_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dms_pkg::REG_MOTIF_PATTERN:  pattern_q <= cfg_data;
				dms_pkg::REG_MOTIF_LENGTH:   length_q  <= cfg_data[dms_pkg::FIELD_LEN_BITS-1:0];
				dms_pkg::REG_MISMATCH_LIMIT: limit_q   <= cfg_data[dms_pkg::FIELD_LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		len_raw = dms_pkg::len_t'(length_q);
		if (len_raw == '0) begin
			len_eff = dms_pkg::len_t'(1);
		end else if (len_raw > dms_pkg::len_t'(M)) begin
			len_eff = dms_pkg::len_t'(M);
		end else begin
			len_eff = len_raw;
		end
	end

	assign lim_ext = dms_pkg::len_t'(limit_q);

	// stage flow control
	assign en4      = !v_s4 || !out_stall;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign acc      = in_valid && en1;

	// stage 1: cell chain and base count
	for (genvar k = 0; k < M; k++) begin : g_cell
		localparam dms_pkg::len_t K = dms_pkg::len_t'(k);
		if (k == 0) begin : g_head
			assign chain_in[k] = base_set;
		end else begin : g_body
			assign chain_in[k] = sequence_start ? '0 : win[k-1];
		end
		dms_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (acc),
			.base_in   (chain_in[k]),
			.fwd_set   (dms_pkg::motif_at(pattern_q, len_eff - K - dms_pkg::len_t'(1))),
			.rev_motif (dms_pkg::motif_at(pattern_q, K)),
			.in_use    (K < len_eff),
			.base_out  (win[k]),
			.mis       (mis[k])
		);
	end

	always_comb begin
		if (sequence_start) begin
			seen_d = dms_pkg::count_t'(1);
		end else if (seen_q == '1) begin
			seen_d = seen_q;
		end else begin
			seen_d = seen_q + dms_pkg::count_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			v_s1   <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
			if (acc) begin
				seen_q <= seen_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			start_s1 <= sequence_start;
		end
	end

	// stage 2: group mismatch counts, window position
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			fcnt_d[g] = '0;
			rcnt_d[g] = '0;
			for (int j = 0; j < dms_pkg::GRP_SIZE; j++) begin
				if (g * dms_pkg::GRP_SIZE + j < M) begin
					fcnt_d[g] = fcnt_d[g] +
						dms_pkg::grp_cnt_t'(mis[g * dms_pkg::GRP_SIZE + j].fwd);
					rcnt_d[g] = rcnt_d[g] +
						dms_pkg::grp_cnt_t'(mis[g * dms_pkg::GRP_SIZE + j].rev);
				end
			end
		end
		full_d = seen_q >= dms_pkg::count_t'(len_eff);
		pos_d  = full_d ? dms_pkg::clamp_out(seen_q - dms_pkg::count_t'(len_eff)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			fcnt_s2  <= fcnt_d;
			rcnt_s2  <= rcnt_d;
			full_s2  <= full_d;
			pos_s2   <= pos_d;
			start_s2 <= start_s1;
		end
	end

	// stage 3: mismatch sums against the limit
	always_comb begin
		fsum = '0;
		rsum = '0;
		for (int g = 0; g < NG; g++) begin
			fsum = fsum + dms_pkg::len_t'(fcnt_s2[g]);
			rsum = rsum + dms_pkg::len_t'(rcnt_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			full_s3  <= full_s2;
			fwd_s3   <= full_s2 && (fsum <= lim_ext);
			rev_s3   <= full_s2 && (rsum <= lim_ext);
			pos_s3   <= pos_s2;
			start_s3 <= start_s2;
		end
	end

	// stage 4: hit tally and output register
	always_comb begin
		hit_base = start_s3 ? '0 : hit_q;
		hit_1    = (fwd_s3 && hit_base != '1) ? hit_base + dms_pkg::count_t'(1) : hit_base;
		hit_2    = (rev_s3 && hit_1 != '1) ? hit_1 + dms_pkg::count_t'(1) : hit_1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			hit_q <= '0;
		end else if (en4) begin
			v_s4 <= v_s3;
			if (v_s3) begin
				hit_q <= hit_2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			window_full    <= full_s3;
			forward_hit    <= fwd_s3;
			reverse_hit    <= rev_s3;
			start_position <= pos_s3;
			total_hits     <= dms_pkg::clamp_out(hit_2);
		end
	end

	assign out_valid = v_s4;

`ifndef SYNTHESIS
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with stage 1 empty");

	a_seen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (seen_q != '0))
		else $error("base count zero after accepted transaction");

	a_hit_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (forward_hit || reverse_hit)) |-> window_full)
		else $error("hit reported on a partial window");

	a_partial_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !window_full) |-> (start_position == '0))
		else $error("nonzero start position on a partial window");
`endif

endmodule

/* tb/dna_motif_scan_with_mismatches_tb.sv */
// ----------------------------------------------------------------------------
// dna_motif_scan_with_mismatches_tb: self-checking bench for the motif scanner
// Sends IUPAC bases through the scanner under several motif, length and
// tolerance settings. Every accepted base is run through a window model, and
// each result transaction is compared with the oldest predicted scan.
// ----------------------------------------------------------------------------
module dna_motif_scan_with_mismatches_tb;
	import dms_pkg::*;

	localparam int   NUM_PHASES   = 10;
	localparam int   PHASE_ITEMS  = 135;
	localparam int   STEP_COUNT   = 25;
	localparam int   HOLD_CYCLES  = 60;
	localparam int   STALL_LIMIT  = 2000;
	localparam base_t BASE_NONE   = 4'h0;
	localparam base_t BASE_A      = 4'h1;
	localparam base_t BASE_C      = 4'h2;
	localparam base_t BASE_G      = 4'h4;
	localparam base_t BASE_T      = 4'h8;
	localparam base_t BASE_N      = 4'hF;

	typedef struct packed {
		logic     full;
		logic     fwd;
		logic     rev;
		out_cnt_t start;
		out_cnt_t hits;
	} scan_result_t;

	function automatic base_t complement_of(base_t m);
		return {m[0], m[1], m[2], m[3]};
	endfunction

	class motif_scan_checker;
		pattern_t     pattern;
		logic [4:0]   length_reg;
		logic [4:0]   limit_reg;
		base_t        window [MAX_MOTIF];
		count_t       bases_in;
		count_t       hit_tally;
		scan_result_t expected_scans [$];
		int           mismatches;

		function new();
			pattern    = '0;
			length_reg = 5'(LENGTH_RESET);
			limit_reg  = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			foreach (window[i]) window[i] = BASE_NONE;
			bases_in  = '0;
			hit_tally = '0;
		endfunction

		function int span();
			if (length_reg == 0)
				return 1;
			if (length_reg > MAX_MOTIF)
				return MAX_MOTIF;
			return int'(length_reg);
		endfunction

		function void write_reg(cfg_reg_t idx, pattern_t d);
			case (idx)
				REG_MOTIF_PATTERN:  pattern = d;
				REG_MOTIF_LENGTH:   length_reg = d[4:0];
				REG_MISMATCH_LIMIT: limit_reg = d[4:0];
				default: ;
			endcase
		endfunction

		function void take_base(base_t b, logic first);
			scan_result_t r;
			int           n;
			int           fwd_miss;
			int           rev_miss;
			base_t        w;
			if (first)
				restart();
			for (int i = MAX_MOTIF - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = b;
			if (bases_in != '1)
				bases_in++;
			n = span();
			r = '0;
			if (bases_in >= n) begin
				fwd_miss = 0;
				rev_miss = 0;
				for (int i = 0; i < n; i++) begin
					w = window[n-1-i];
					if ((w & pattern[4*i +: 4]) == 0)
						fwd_miss++;
					if ((w & complement_of(pattern[4*(n-1-i) +: 4])) == 0)
						rev_miss++;
				end
				r.full  = 1'b1;
				r.fwd   = fwd_miss <= limit_reg;
				r.rev   = rev_miss <= limit_reg;
				r.start = bases_in - n;
				if (r.fwd && hit_tally != '1)
					hit_tally++;
				if (r.rev && hit_tally != '1)
					hit_tally++;
			end
			r.hits = hit_tally;
			expected_scans.insert(expected_scans.size(), r);
		endfunction

		function void match_result(scan_result_t got);
			scan_result_t want;
			if (expected_scans.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none pending: full=%0b fwd=%0b rev=%0b start=%0d hits=%0d",
						$time, got.full, got.fwd, got.rev, got.start, got.hits);
				return;
			end
			want = expected_scans.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: exp full=%0b fwd=%0b rev=%0b start=%0d hits=%0d, got full=%0b fwd=%0b rev=%0b start=%0d hits=%0d",
						$time, want.full, want.fwd, want.rev, want.start, want.hits,
						got.full, got.fwd, got.rev, got.start, got.hits);
			end
		endfunction
	endclass

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      cfg_valid      = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index      = REG_MOTIF_PATTERN;
	pattern_t                  cfg_data       = '0;
	logic                      in_valid       = 1'b0;
	logic                      in_stall;
	base_t                     base_set       = BASE_NONE;
	logic                      sequence_start = 1'b0;
	logic                      out_valid;
	logic                      out_stall      = 1'b0;
	logic                      window_full;
	logic                      forward_hit;
	logic                      reverse_hit;
	logic [31:0]               start_position;
	logic [31:0]               total_hits;

	motif_scan_checker sb = new();
	base_t             planted [$];
	int                send_idle = 37;
	int                recv_idle = 54;
	bit                hold_req  = 1'b0;
	bit                hold_done = 1'b0;
	int                hold_left = 0;
	int                quiet_cycles = 0;

	dna_motif_scan_with_mismatches u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.base_set       (base_set),
		.sequence_start (sequence_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.window_full    (window_full),
		.forward_hit    (forward_hit),
		.reverse_hit    (reverse_hit),
		.start_position (start_position),
		.total_hits     (total_hits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic base_t rand_base();
		if ($urandom_range(0, 9) < 7)
			return base_t'(1 << $urandom_range(0, 3));
		return base_t'($urandom_range(0, 15));
	endfunction

	function automatic pattern_t rand_motif();
		pattern_t p;
		for (int i = 0; i < MOTIF_SLOTS; i++)
			p[4*i +: 4] = rand_base();
		return p;
	endfunction

	// mostly random bases, with copies of the motif on either strand planted in
	function automatic base_t next_base();
		int    n;
		bit    rev;
		base_t m;
		base_t b;
		if (planted.size() == 0 && $urandom_range(0, 99) < 35) begin
			n   = sb.span();
			rev = $urandom_range(0, 1);
			for (int i = 0; i < n; i++) begin
				m = rev ? complement_of(sb.pattern[4*(n-1-i) +: 4]) : sb.pattern[4*i +: 4];
				b = m & base_t'($urandom_range(0, 15));
				planted.insert(planted.size(), (b == BASE_NONE || $urandom_range(0, 1)) ? m : b);
			end
			repeat ($urandom_range(0, 2))
				planted[$urandom_range(0, n - 1)] = rand_base();
		end
		if (planted.size() != 0)
			return planted.pop_front();
		return rand_base();
	endfunction

	task automatic apply_config(pattern_t pat, logic [4:0] len, logic [4:0] lim);
		cfg_reg_t order [3];
		pattern_t value;
		order = '{REG_MOTIF_PATTERN, REG_MOTIF_LENGTH, REG_MISMATCH_LIMIT};
		foreach (order[k]) begin
			value = {$urandom, $urandom};
			case (order[k])
				REG_MOTIF_PATTERN: value = pat;
				REG_MOTIF_LENGTH:  value[4:0] = len;
				default:           value[4:0] = lim;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= order[k];
			cfg_data  <= value;
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(order[k], value);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_base(base_t b, logic first);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		base_set       <= b;
		sequence_start <= first;
		do @(posedge clk); while (in_stall);
		sb.take_base(b, first);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_scans.size() != 0)
			@(posedge clk);
	endtask

	// result side: check, then pick the next stall
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.match_result({window_full, forward_hit, reverse_hit, start_position, total_hits});
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(0, 99) < recv_idle;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		pattern_t              pat;
		logic [4:0]            len;
		logic [4:0]            lim;
		base_t                 steps [STEP_COUNT];
		logic [STEP_COUNT-1:0] step_first;
		steps = '{BASE_A, BASE_C, BASE_G, BASE_T, BASE_N, BASE_N, BASE_N, BASE_N, BASE_NONE,
			BASE_T, BASE_G, BASE_C, BASE_A, BASE_A, BASE_C, BASE_G, BASE_T,
			BASE_NONE, BASE_NONE, BASE_NONE, BASE_NONE, BASE_N, 4'h5, 4'hA, 4'h3};
		step_first = '0;
		step_first[0]  = 1'b1;
		step_first[9]  = 1'b1;
		step_first[17] = 1'b1;
		step_first[21] = 1'b1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle = (p < 4) ? 37 : (p < 7) ? 54 : 0;
			recv_idle = (p < 4) ? 54 : (p < 7) ? 37 : 0;
			pat = rand_motif();
			case (p)
				0: begin
					pat[15:0] = {BASE_T, BASE_G, BASE_C, BASE_A};
					len = 5'd4;
					lim = 5'd0;
				end
				1: begin len = 5'd16; lim = 5'd0; end
				2: begin len = 5'd1;  lim = 5'd0; end
				3: begin len = 5'd0;  lim = 5'd1; end
				4: begin len = 5'd8;  lim = 5'd2; end
				5: begin len = 5'd31; lim = 5'd3; end
				6: begin pat = '0; len = 5'd5;  lim = 5'd4; end
				7: begin pat = '1; len = 5'd12; lim = 5'd16; end
				8: begin
					pat = {$urandom, $urandom};
					len = 5'($urandom_range(1, 16));
					lim = 5'd31;
				end
				default: begin
					// palindromic motif: reverse complement equals itself
					for (int i = 0; i < 3; i++)
						pat[4*(5-i) +: 4] = complement_of(pat[4*i +: 4]);
					len = 5'd6;
					lim = 5'd1;
				end
			endcase
			apply_config(pat, len, lim);
			if (p == 0) begin
				for (int k = 0; k < STEP_COUNT; k++)
					send_base(steps[k], step_first[k]);
			end else begin
				for (int k = 0; k < PHASE_ITEMS; k++) begin
					if (p == 2 && k == 40)
						hold_req = 1'b1;
					if (p == 5 && k == 60)
						drain();
					send_base(next_base(), $urandom_range(0, 99) < 3);
				end
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_scans.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
